>>> rtl/ffs_pkg.sv
`timescale 1ns / 1ps
// ffs_pkg: shared types, codes and constants of the flat face shading unit
// no dependencies; used by every module of the block

package ffs_pkg;

  // default fraction bits of the signed fixed point normals and yaw terms
  localparam int FRACTION_BITS = 14;

  // fixed field widths
  localparam int NORMAL_W    = 16;
  localparam int MATERIAL_W  = 3;
  localparam int COLOR_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // rotated x and z: sum of two 16x16 signed products
  localparam int ROT_W = 2 * NORMAL_W + 1;

  // material codes, anything else is unknown
  typedef enum logic [MATERIAL_W-1:0] {
    MAT_BODY      = 3'd0,
    MAT_WINDOW    = 3'd1,
    MAT_WHEEL     = 3'd2,
    MAT_HEADLIGHT = 3'd3,
    MAT_TAILLIGHT = 3'd4
  } material_e;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_YAW_SINE   = 3'd0,
    REG_YAW_COSINE = 3'd1,
    REG_BODY_RED   = 3'd2,
    REG_BODY_GREEN = 3'd3,
    REG_BODY_BLUE  = 3'd4
  } cfg_reg_e;

  // fixed material colours
  localparam logic [COLOR_W-1:0] WHEEL_GREY   = 8'd40;
  localparam logic [COLOR_W-1:0] WINDOW_RED   = 8'd0;
  localparam logic [COLOR_W-1:0] WINDOW_GREEN = 8'd50;
  localparam logic [COLOR_W-1:0] WINDOW_BLUE  = 8'd200;
  localparam logic [COLOR_W-1:0] FULL_LEVEL   = 8'd255;
  localparam logic [COLOR_W-1:0] ZERO_LEVEL   = 8'd0;

  // body base colour as held in the configuration registers
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } ffs_body_t;

  // one face as it enters the block
  typedef struct packed {
    logic signed [NORMAL_W-1:0] normal_x;
    logic signed [NORMAL_W-1:0] normal_y;
    logic signed [NORMAL_W-1:0] normal_z;
    logic [MATERIAL_W-1:0]      material;
  } ffs_item_t;

  // one shaded face colour
  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               keep_previous;
  } ffs_result_t;

endpackage

>>> rtl/flat_face_shading.sv
`timescale 1ns / 1ps
// flat_face_shading: top level, configuration registers and the shading pipeline
// depends on ffs_pkg, ffs_rotate, ffs_light and ffs_color

// Flat shading of one face per clock. A face is taken whenever start is high;
// busy never rises, since the five-stage pipeline (two rotation stages, two
// lighting stages, one colour stage) always moves on. Each face gives exactly
// one colour, shown on result_o for one cycle with done_o high, in the order
// the faces arrived. The receiver must take each result in that cycle.
// Configuration writes are always accepted (cfg_ready_o is tied high) and
// should be made only while no face is in flight.

module flat_face_shading #(
  parameter int FracBits = ffs_pkg::FRACTION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  ffs_pkg::ffs_item_t              item_i,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ffs_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ffs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                            done_o,
  output ffs_pkg::ffs_result_t            result_o
);

  localparam int NormW = ffs_pkg::NORMAL_W;
  localparam int ColW  = ffs_pkg::COLOR_W;
  localparam logic [NormW-1:0] CosReset = NormW'(1 << FracBits);

  // configuration registers
  logic signed [NormW-1:0] yaw_sine_q, yaw_cosine_q;
  ffs_pkg::ffs_body_t      body_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_sine_q   <= '0;
      yaw_cosine_q <= CosReset;
      body_q       <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ffs_pkg::cfg_reg_e'(cfg_index_i))
        ffs_pkg::REG_YAW_SINE:   yaw_sine_q   <= cfg_data_i[NormW-1:0];
        ffs_pkg::REG_YAW_COSINE: yaw_cosine_q <= cfg_data_i[NormW-1:0];
        ffs_pkg::REG_BODY_RED:   body_q.red   <= cfg_data_i[ColW-1:0];
        ffs_pkg::REG_BODY_GREEN: body_q.green <= cfg_data_i[ColW-1:0];
        ffs_pkg::REG_BODY_BLUE:  body_q.blue  <= cfg_data_i[ColW-1:0];
        default: ;
      endcase
    end
  end

  // input transfer
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // rotation
  logic                                   rot_valid;
  logic signed [ffs_pkg::ROT_W-1:0]       rot_x, rot_z;
  logic signed [NormW+FracBits-1:0]       rot_y;
  logic [ffs_pkg::MATERIAL_W-1:0]         rot_mat;

  ffs_rotate #(
    .FracBits(FracBits)
  ) u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .item_i      (item_i),
    .yaw_sine_i  (yaw_sine_q),
    .yaw_cosine_i(yaw_cosine_q),
    .valid_o     (rot_valid),
    .rot_x_o     (rot_x),
    .rot_y_o     (rot_y),
    .rot_z_o     (rot_z),
    .material_o  (rot_mat)
  );

  // lighting
  logic                           lit_valid;
  logic [FracBits:0]              lit_inten;
  logic [ffs_pkg::MATERIAL_W-1:0] lit_mat;

  ffs_light #(
    .FracBits(FracBits)
  ) u_light (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (rot_valid),
    .rot_x_i    (rot_x),
    .rot_y_i    (rot_y),
    .rot_z_i    (rot_z),
    .material_i (rot_mat),
    .valid_o    (lit_valid),
    .intensity_o(lit_inten),
    .material_o (lit_mat)
  );

  // colour
  ffs_color #(
    .FracBits(FracBits)
  ) u_color (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (lit_valid),
    .intensity_i(lit_inten),
    .material_i (lit_mat),
    .body_i     (body_q),
    .valid_o    (done_o),
    .result_o   (result_o)
  );

  // every result comes from a matching face taken earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 5))
    else $error("result without a matching face");

  // every face taken gives a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 done_o)
    else $error("face taken but no result");

  // an unknown material carries a zero colour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.keep_previous) |->
      (result_o.red == '0 && result_o.green == '0 && result_o.blue == '0))
    else $error("keep flag with a nonzero colour");

  // the keep flag follows the material code of the face
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.keep_previous ==
      ($past(item_i.material, 5) > ffs_pkg::MAT_TAILLIGHT)))
    else $error("keep flag does not match the material");

endmodule

>>> rtl/ffs_rotate.sv
`timescale 1ns / 1ps
// ffs_rotate: yaw rotation of the face normal, two register stages
// depends on ffs_pkg

module ffs_rotate #(
  parameter int FracBits = ffs_pkg::FRACTION_BITS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  input  ffs_pkg::ffs_item_t                           item_i,
  input  logic signed [ffs_pkg::NORMAL_W-1:0]          yaw_sine_i,
  input  logic signed [ffs_pkg::NORMAL_W-1:0]          yaw_cosine_i,
  output logic                                         valid_o,
  output logic signed [ffs_pkg::ROT_W-1:0]             rot_x_o,
  output logic signed [ffs_pkg::NORMAL_W+FracBits-1:0] rot_y_o,
  output logic signed [ffs_pkg::ROT_W-1:0]             rot_z_o,
  output logic [ffs_pkg::MATERIAL_W-1:0]               material_o
);

  localparam int ProdW = 2 * ffs_pkg::NORMAL_W;
  localparam int RotW  = ffs_pkg::ROT_W;
  localparam int RyW   = ffs_pkg::NORMAL_W + FracBits;

  // stage 1: the four rotation products
  logic signed [ProdW-1:0] prod_xc_d, prod_zs_d, prod_zc_d, prod_xs_d;
  logic signed [ProdW-1:0] prod_xc_q, prod_zs_q, prod_zc_q, prod_xs_q;
  logic signed [ffs_pkg::NORMAL_W-1:0] ny_q;
  logic [ffs_pkg::MATERIAL_W-1:0]      mat1_q;
  logic                                vld1_q;

  assign prod_xc_d = item_i.normal_x * yaw_cosine_i;
  assign prod_zs_d = item_i.normal_z * yaw_sine_i;
  assign prod_zc_d = item_i.normal_z * yaw_cosine_i;
  assign prod_xs_d = item_i.normal_x * yaw_sine_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else begin
      vld1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_xc_q <= prod_xc_d;
    prod_zs_q <= prod_zs_d;
    prod_zc_q <= prod_zc_d;
    prod_xs_q <= prod_xs_d;
    ny_q      <= item_i.normal_y;
    mat1_q    <= item_i.material;
  end

  // stage 2: combine into the rotated normal, y scaled up to the same point
  logic signed [RotW-1:0] rx_d, rz_d, rx_q, rz_q;
  logic signed [RyW-1:0]  ry_d, ry_q;
  logic [ffs_pkg::MATERIAL_W-1:0] mat2_q;
  logic                           vld2_q;

  assign rx_d = RotW'(prod_xc_q) + RotW'(prod_zs_q);
  assign rz_d = RotW'(prod_zc_q) - RotW'(prod_xs_q);
  assign ry_d = $signed({ny_q, {FracBits{1'b0}}});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rx_q   <= rx_d;
    ry_q   <= ry_d;
    rz_q   <= rz_d;
    mat2_q <= mat1_q;
  end

  assign valid_o    = vld2_q;
  assign rot_x_o    = rx_q;
  assign rot_y_o    = ry_q;
  assign rot_z_o    = rz_q;
  assign material_o = mat2_q;

endmodule

>>> rtl/ffs_light.sv
`timescale 1ns / 1ps
// ffs_light: dot product with the fixed light vector and intensity clamp
// depends on ffs_pkg; two register stages

module ffs_light #(
  parameter int FracBits = ffs_pkg::FRACTION_BITS
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         valid_i,
  input  logic signed [ffs_pkg::ROT_W-1:0]             rot_x_i,
  input  logic signed [ffs_pkg::NORMAL_W+FracBits-1:0] rot_y_i,
  input  logic signed [ffs_pkg::ROT_W-1:0]             rot_z_i,
  input  logic [ffs_pkg::MATERIAL_W-1:0]               material_i,
  output logic                                         valid_o,
  output logic [FracBits:0]                            intensity_o,
  output logic [ffs_pkg::MATERIAL_W-1:0]               material_o
);

  localparam int OneFx     = 1 << FracBits;
  localparam int LightXInt = -(OneFx / 2);
  localparam int LightYInt = -((OneFx * 8 + 5) / 10);
  localparam int LightZInt = OneFx / 2;
  localparam int LightMin  = (OneFx * 45 + 50) / 100;
  localparam int IntW      = FracBits + 1;
  localparam int DotW      = ffs_pkg::ROT_W + FracBits + 3;
  localparam int ShW       = DotW - 2 * FracBits;

  localparam logic signed [IntW-1:0] LightX = IntW'(LightXInt);
  localparam logic signed [IntW-1:0] LightY = IntW'(LightYInt);
  localparam logic signed [IntW-1:0] LightZ = IntW'(LightZInt);
  localparam logic [ShW-1:0]         OneSh  = ShW'(OneFx);
  localparam logic [ShW-1:0]         MinSh  = ShW'(LightMin);

  // stage 3: products with the light components
  logic signed [DotW-1:0] px_d, py_d, pz_d, px_q, py_q, pz_q;
  logic [ffs_pkg::MATERIAL_W-1:0] mat3_q;
  logic                           vld3_q;

  assign px_d = rot_x_i * LightX;
  assign py_d = rot_y_i * LightY;
  assign pz_d = rot_z_i * LightZ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else begin
      vld3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    py_q   <= py_d;
    pz_q   <= pz_d;
    mat3_q <= material_i;
  end

  // stage 4: sum, magnitude, truncate and clamp
  logic signed [DotW-1:0] dot;
  logic [DotW-1:0]        mag;
  logic [ShW-1:0]         mag_sh;
  logic [IntW-1:0]        inten_d, inten_q;
  logic [ffs_pkg::MATERIAL_W-1:0] mat4_q;
  logic                           vld4_q;

  assign dot    = px_q + py_q + pz_q;
  assign mag    = dot[DotW-1] ? DotW'(-dot) : DotW'(dot);
  assign mag_sh = mag[DotW-1:2*FracBits];

  always_comb begin
    if (mag_sh < MinSh) begin
      inten_d = MinSh[IntW-1:0];
    end else if (mag_sh > OneSh) begin
      inten_d = OneSh[IntW-1:0];
    end else begin
      inten_d = mag_sh[IntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
    end else begin
      vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    inten_q <= inten_d;
    mat4_q  <= mat3_q;
  end

  assign valid_o     = vld4_q;
  assign intensity_o = inten_q;
  assign material_o  = mat4_q;

endmodule

>>> rtl/ffs_color.sv
`timescale 1ns / 1ps
// ffs_color: material colour selection and shading, output register stage
// depends on ffs_pkg

module ffs_color #(
  parameter int FracBits = ffs_pkg::FRACTION_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [FracBits:0]              intensity_i,
  input  logic [ffs_pkg::MATERIAL_W-1:0] material_i,
  input  ffs_pkg::ffs_body_t             body_i,
  output logic                           valid_o,
  output ffs_pkg::ffs_result_t           result_o
);

  localparam int ShadeW = ffs_pkg::COLOR_W + FracBits + 1;

  // shaded levels; intensity never exceeds one, so no saturation
  logic [ShadeW-1:0] prod_r, prod_g, prod_b, prod_w;

  assign prod_r = body_i.red   * intensity_i;
  assign prod_g = body_i.green * intensity_i;
  assign prod_b = body_i.blue  * intensity_i;
  assign prod_w = ffs_pkg::WHEEL_GREY * intensity_i;

  ffs_pkg::ffs_result_t res_d, res_q;
  logic                 vld_q;

  // colour by material
  always_comb begin
    res_d = '0;
    unique case (ffs_pkg::material_e'(material_i))
      ffs_pkg::MAT_BODY: begin
        res_d.red   = prod_r[FracBits +: ffs_pkg::COLOR_W];
        res_d.green = prod_g[FracBits +: ffs_pkg::COLOR_W];
        res_d.blue  = prod_b[FracBits +: ffs_pkg::COLOR_W];
      end
      ffs_pkg::MAT_WINDOW: begin
        res_d.red   = ffs_pkg::WINDOW_RED;
        res_d.green = ffs_pkg::WINDOW_GREEN;
        res_d.blue  = ffs_pkg::WINDOW_BLUE;
      end
      ffs_pkg::MAT_WHEEL: begin
        res_d.red   = prod_w[FracBits +: ffs_pkg::COLOR_W];
        res_d.green = prod_w[FracBits +: ffs_pkg::COLOR_W];
        res_d.blue  = prod_w[FracBits +: ffs_pkg::COLOR_W];
      end
      ffs_pkg::MAT_HEADLIGHT: begin
        res_d.red   = ffs_pkg::FULL_LEVEL;
        res_d.green = ffs_pkg::FULL_LEVEL;
        res_d.blue  = ffs_pkg::FULL_LEVEL;
      end
      ffs_pkg::MAT_TAILLIGHT: begin
        res_d.red   = ffs_pkg::FULL_LEVEL;
        res_d.green = ffs_pkg::ZERO_LEVEL;
        res_d.blue  = ffs_pkg::ZERO_LEVEL;
      end
      default: begin
        res_d.keep_previous = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = vld_q;
  assign result_o = res_q;

endmodule

>>> bench/ffs_shade_checker.sv
`timescale 1ns / 1ps
// ffs_shade_checker: predicts the shaded colour of every face taken by the block
// and compares it with each result; depends on ffs_pkg only

module ffs_shade_checker #(
  parameter int FracBits = ffs_pkg::FRACTION_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            busy_i,
  input  ffs_pkg::ffs_item_t              item_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [ffs_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ffs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            done_i,
  input  ffs_pkg::ffs_result_t            result_i,
  output int                              errors_o,
  output int                              pending_o
);
  import ffs_pkg::*;

  // light vector and intensity bounds at FracBits fraction bits
  localparam longint One      = longint'(1) <<< FracBits;
  localparam longint LightX   = -(One / 2);
  localparam longint LightY   = -((One * 8 + 5) / 10);
  localparam longint LightZ   = One / 2;
  localparam longint LightMin = (One * 45 + 50) / 100;

  // own copy of the configuration registers
  logic signed [NORMAL_W-1:0] yaw_sin;
  logic signed [NORMAL_W-1:0] yaw_cos;
  ffs_body_t                  body_color;

  ffs_result_t expected_colors[$];
  int          error_count = 0;
  int          reported    = 0;

  // colour of one face under the current yaw and body colour
  function automatic ffs_result_t shade_face(ffs_item_t face);
    longint      nx, ny, nz, s, c;
    longint      rot_x, rot_y, rot_z, dot, mag, level;
    ffs_result_t res;
    nx    = longint'($signed(face.normal_x));
    ny    = longint'($signed(face.normal_y));
    nz    = longint'($signed(face.normal_z));
    s     = longint'(yaw_sin);
    c     = longint'(yaw_cos);
    rot_x = nx * c + nz * s;
    rot_y = ny * One;
    rot_z = nz * c - nx * s;
    dot   = rot_x * LightX + rot_y * LightY + rot_z * LightZ;
    mag   = (dot < 0) ? -dot : dot;
    level = mag >>> (2 * FracBits);
    if (level < LightMin) level = LightMin;
    if (level > One) level = One;
    res = '0;
    case (face.material)
      MAT_BODY: begin
        res.red   = COLOR_W'((longint'(body_color.red) * level) >>> FracBits);
        res.green = COLOR_W'((longint'(body_color.green) * level) >>> FracBits);
        res.blue  = COLOR_W'((longint'(body_color.blue) * level) >>> FracBits);
      end
      MAT_WINDOW: begin
        res.red   = WINDOW_RED;
        res.green = WINDOW_GREEN;
        res.blue  = WINDOW_BLUE;
      end
      MAT_WHEEL: begin
        res.red   = COLOR_W'((longint'(WHEEL_GREY) * level) >>> FracBits);
        res.green = res.red;
        res.blue  = res.red;
      end
      MAT_HEADLIGHT: begin
        res.red   = FULL_LEVEL;
        res.green = FULL_LEVEL;
        res.blue  = FULL_LEVEL;
      end
      MAT_TAILLIGHT: begin
        res.red   = FULL_LEVEL;
        res.green = ZERO_LEVEL;
        res.blue  = ZERO_LEVEL;
      end
      default: begin
        res.keep_previous = 1'b1;
      end
    endcase
    return res;
  endfunction

  // register transfers, result compare, then prediction of the face taken
  always @(posedge clk_i or negedge rst_ni) begin
    ffs_result_t want;
    if (!rst_ni) begin
      yaw_sin    = '0;
      yaw_cos    = NORMAL_W'(One);
      body_color = '0;
      expected_colors.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_YAW_SINE:   yaw_sin          = cfg_data_i;
          REG_YAW_COSINE: yaw_cos          = cfg_data_i;
          REG_BODY_RED:   body_color.red   = cfg_data_i[COLOR_W-1:0];
          REG_BODY_GREEN: body_color.green = cfg_data_i[COLOR_W-1:0];
          REG_BODY_BLUE:  body_color.blue  = cfg_data_i[COLOR_W-1:0];
          default: ;
        endcase
      end
      if (done_i) begin
        if (expected_colors.size() == 0) begin
          error_count++;
          if (reported < 10) begin
            reported++;
            $display("%0t: result with nothing pending: r=%0d g=%0d b=%0d keep=%0b",
                     $realtime, result_i.red, result_i.green, result_i.blue,
                     result_i.keep_previous);
          end
        end else begin
          want = expected_colors.pop_front();
          if (result_i.red !== want.red || result_i.green !== want.green ||
              result_i.blue !== want.blue || result_i.keep_previous !== want.keep_previous) begin
            error_count++;
            if (reported < 10) begin
              reported++;
              $display("%0t: colour mismatch: expected r=%0d g=%0d b=%0d keep=%0b",
                       $realtime, want.red, want.green, want.blue, want.keep_previous);
              $display("%0t:                  actual   r=%0d g=%0d b=%0d keep=%0b",
                       $realtime, result_i.red, result_i.green, result_i.blue,
                       result_i.keep_previous);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_colors.push_back(shade_face(item_i));
      end
    end
    errors_o  <= error_count;
    pending_o <= expected_colors.size();
  end

endmodule

>>> bench/tb_flat_face_shading.sv
`timescale 1ns / 1ps
// tb_flat_face_shading: stimulus, watchdog and verdict for the flat face shading unit
// depends on ffs_pkg, flat_face_shading and ffs_shade_checker

module tb_flat_face_shading;
  import ffs_pkg::*;

  localparam int DrainCycles = 16;
  localparam int StallLimit  = 2000;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   start       = 1'b0;
  ffs_item_t              item_i      = '0;
  logic                   cfg_valid_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;
  logic                   busy;
  logic                   cfg_ready_o;
  logic                   done_o;
  ffs_result_t            result_o;
  int                     errors;
  int                     pending;

  flat_face_shading DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  ffs_shade_checker shade_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_i      (busy),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .done_i      (done_o),
    .result_i    (result_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // random normal component, mostly within +-1.0, sometimes any pattern
  function automatic logic [NORMAL_W-1:0] rand_normal();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return NORMAL_W'($urandom);
    if (pick == 1) return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
    return NORMAL_W'($urandom_range(0, 32768) - 16384);
  endfunction

  function automatic ffs_item_t rand_face();
    ffs_item_t face;
    face.normal_x = rand_normal();
    face.normal_y = rand_normal();
    face.normal_z = rand_normal();
    face.material = MATERIAL_W'($urandom_range(0, 7));
    return face;
  endfunction

  // one face transfer; start stays high for a face that follows right away
  task automatic push_face(input ffs_item_t face);
    start  <= 1'b1;
    item_i <= face;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // start low for the requested idle time, with noise on the face lines
  task automatic idle_faces(input int cycles);
    start  <= 1'b0;
    item_i <= rand_face();
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // wait until every pending colour has come out, plus pipeline slack
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all registers, a stray index too, with random gaps between writes
  task automatic write_setting(input logic [CFG_DATA_W-1:0] sine,
                               input logic [CFG_DATA_W-1:0] cosine,
                               input logic [COLOR_W-1:0] r,
                               input logic [COLOR_W-1:0] g,
                               input logic [COLOR_W-1:0] b);
    logic [CFG_DATA_W-1:0] data [5];
    int                    k;
    data[0] = sine;
    data[1] = cosine;
    data[2] = {8'($urandom), r};
    data[3] = {8'($urandom), g};
    data[4] = {8'($urandom), b};
    for (k = 0; k < 5; k++) begin
      while ($urandom_range(0, 99) < 21) begin
        cfg_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      cfg_write(CFG_INDEX_W'(REG_YAW_SINE) + CFG_INDEX_W'(k), data[k]);
    end
    // indexes past the last register are ignored
    cfg_write(CFG_INDEX_W'(REG_BODY_BLUE) + CFG_INDEX_W'($urandom_range(1, 3)),
              CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) stalled = 0;
      else stalled++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    ffs_item_t             face;
    logic [CFG_DATA_W-1:0] sine, cosine;
    logic [COLOR_W-1:0]    r, g, b;
    int                    m, phase, k, count;
    bit                    gaps;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: black body, unrotated
    face = '{normal_x: 16'sd0, normal_y: -16'sd16384, normal_z: 16'sd0, material: MAT_BODY};
    push_face(face);
    face.material = MAT_WHEEL;
    push_face(face);
    settle();

    write_setting(16'sd0, 16'sd16384, 8'd255, 8'd128, 8'd1);

    // every material code, lit straight from above
    for (m = 0; m < 8; m++) begin
      face.material = MATERIAL_W'(m);
      push_face(face);
    end

    // zero normal clamps to the minimum level
    face = '{normal_x: 16'sd0, normal_y: 16'sd0, normal_z: 16'sd0, material: MAT_BODY};
    push_face(face);
    face.material = MAT_WHEEL;
    push_face(face);

    // bright face clamps to full level
    face = '{normal_x: -16'sd16384, normal_y: -16'sd16384, normal_z: 16'sd16384,
             material: MAT_BODY};
    push_face(face);

    // 16-bit extremes beyond +-1.0
    face = '{normal_x: 16'h7fff, normal_y: 16'h7fff, normal_z: 16'h7fff, material: MAT_BODY};
    push_face(face);
    face = '{normal_x: 16'h8000, normal_y: 16'h8000, normal_z: 16'h8000, material: MAT_BODY};
    push_face(face);
    face = '{normal_x: 16'h8000, normal_y: 16'h7fff, normal_z: 16'h8000, material: MAT_WHEEL};
    push_face(face);

    // single x and z components
    face = '{normal_x: 16'sd16384, normal_y: 16'sd0, normal_z: 16'sd0, material: MAT_WHEEL};
    push_face(face);
    face = '{normal_x: 16'sd0, normal_y: 16'sd0, normal_z: -16'sd16384, material: MAT_WHEEL};
    push_face(face);
    settle();

    // random phases, each under its own setting
    for (phase = 0; phase < 8; phase++) begin
      r = 8'($urandom);
      g = 8'($urandom);
      b = 8'($urandom);
      case (phase)
        0: begin
          sine = 16'sd0; cosine = 16'sd16384; r = 8'd255; g = 8'd255; b = 8'd255;
        end
        1: begin
          sine = 16'sd16384; cosine = 16'sd0; r = 8'd0; g = 8'd0; b = 8'd0;
        end
        2: begin
          sine = -16'sd16384; cosine = -16'sd16384; r = 8'd255; g = 8'd0; b = 8'd255;
        end
        3: begin
          sine = 16'h7fff; cosine = 16'h8000;
        end
        default: begin
          sine   = CFG_DATA_W'($urandom_range(0, 32768) - 16384);
          cosine = CFG_DATA_W'($urandom_range(0, 32768) - 16384);
        end
      endcase
      write_setting(sine, cosine, r, g, b);

      // one long back-to-back stretch, gaps everywhere else
      gaps  = (phase != 4);
      count = gaps ? 58 : 100;
      for (k = 0; k < count; k++) begin
        while (gaps && $urandom_range(0, 99) < 21) idle_faces(1);
        push_face(rand_face());
      end
      settle();
    end

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
